// ===== rtl/pae_pkg.sv =====
// ----------------------------------------------------------------------------
// pae_pkg
// Shared widths, codes and controller/datapath interface types for the
// playhead anchor extrapolator.
// ----------------------------------------------------------------------------
package pae_pkg;

   localparam int WORD_W = 64;
   localparam int ADDR_W = 4;

   localparam logic [WORD_W-1:0] STAMP_RATE_RESET = 64'd10000000;
   localparam logic [WORD_W-1:0] POS_RATE_RESET   = 64'd48000;
   localparam logic [WORD_W-1:0] MS_PER_SEC       = 64'd1000;
   localparam logic [WORD_W-1:0] SLACK_DIV        = 64'd1000;

   // slack = ((pos_rate >> 3) * SLACK_RECIP) >> 68, exact for every 64-bit rate
   localparam int SLACK_PRESHIFT = 3;
   localparam int SLACK_SHIFT    = 68;
   localparam logic [WORD_W-1:0] SLACK_RECIP = WORD_W'(((128'd1 << SLACK_SHIFT) /
      {64'd0, SLACK_DIV >> SLACK_PRESHIFT}) + 128'd1);

   // register indexes (byte address bit 3)
   localparam logic REG_STAMP_RATE = 1'b0;
   localparam logic REG_POS_RATE   = 1'b1;

   // divider operand selections
   localparam logic [1:0] DIV_HW    = 2'd0;
   localparam logic [1:0] DIV_PRED  = 2'd1;
   localparam logic [1:0] DIV_SLACK = 2'd2;
   localparam logic [1:0] DIV_MS    = 2'd3;

   // command codes of an item
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_EPOCH = 1'b1;

   typedef struct packed {
      logic       load_item;
      logic       div_start;
      logic [1:0] div_sel;
      logic       div_capture;
      logic       settle;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd;
      logic read_ok;
      logic epoch_valid;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/playhead_anchor_extrapolator_top.sv =====
// ----------------------------------------------------------------------------
// playhead_anchor_extrapolator_top
// Anchored playhead extrapolation with monotonic output and song-time
// conversion; register port, sequencer and datapath.
// ----------------------------------------------------------------------------
// Sequence: a position query runs three passes of the shared serial mul-div
//   unit (each a multiply from four partial products, then a bit-serial divide)
//   and a reciprocal multiply for the slack, besides settle and output steps;
//   an epoch with a good read runs one pass; other items need no arithmetic.
// Throughput: one item at a time, set by the serial mul-div unit.
// Reset: synchronous; rates return to 10000000 and 48000, state clears.
module playhead_anchor_extrapolator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic                                req_read_ok,
   input  logic [pae_pkg::WORD_W-1:0]          req_hw_pos,
   input  logic [pae_pkg::WORD_W-1:0]          req_hw_stamp,
   input  logic [pae_pkg::WORD_W-1:0]          req_now_stamp,
   input  logic signed [pae_pkg::WORD_W-1:0]   req_song_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pos_valid,
   output logic [pae_pkg::WORD_W-1:0]          rsp_smooth_pos,
   output logic signed [pae_pkg::WORD_W-1:0]   rsp_position_ms,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pae_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [pae_pkg::WORD_W-1:0]          csr_pwdata,
   output logic [pae_pkg::WORD_W-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import pae_pkg::*;

   ctrl_cmd_type      ctrl;
   dp_status_type     status;
   logic              cfg_we;
   logic [WORD_W-1:0] stamp_rate, pos_rate;

   // decode register access
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      if (csr_paddr[2:0] != 3'd0) begin
         csr_prdata = '0;
      end else if (csr_paddr[3] == REG_STAMP_RATE) begin
         csr_prdata = stamp_rate;
      end else begin
         csr_prdata = pos_rate;
      end
   end

   pae_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .status   (status),
      .ctrl     (ctrl)
   );

   pae_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .cfg_we          (cfg_we),
      .cfg_idx         (csr_paddr[3]),
      .cfg_wdata       (csr_pwdata),
      .stamp_rate      (stamp_rate),
      .pos_rate        (pos_rate),
      .in_cmd          (req_cmd),
      .in_read_ok      (req_read_ok),
      .in_hw_pos       (req_hw_pos),
      .in_hw_stamp     (req_hw_stamp),
      .in_now_stamp    (req_now_stamp),
      .in_song_ms      (req_song_ms),
      .out_ready       (rsp_ready),
      .out_valid       (rsp_valid),
      .out_pos_valid   (rsp_pos_valid),
      .out_smooth_pos  (rsp_smooth_pos),
      .out_position_ms (rsp_position_ms)
   );

endmodule

// ===== rtl/pae_muldiv.sv =====
// ----------------------------------------------------------------------------
// pae_muldiv
// Serial floor(a*b/d): 128-bit product from four 32x32 partial products,
// then a restoring divide one bit per cycle. Quotient is the low 64 bits,
// zero when d is zero. In reciprocal mode the divide is skipped and the
// result is the product shifted right by SLACK_SHIFT.
// ----------------------------------------------------------------------------
module pae_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       recip,
   input  logic [pae_pkg::WORD_W-1:0] a,
   input  logic [pae_pkg::WORD_W-1:0] b,
   input  logic [pae_pkg::WORD_W-1:0] d,
   output logic                       done,
   output logic [pae_pkg::WORD_W-1:0] quot
);
   import pae_pkg::*;

   logic                busy_ff, busy_in;
   logic                mul_ff, mul_in;
   logic                done_ff, done_in;
   logic                recip_ff, recip_in;
   logic [6:0]          step_ff, step_in;
   logic [WORD_W-1:0]   a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0]   rem_ff, rem_in, quot_ff, quot_in;

   logic [31:0]         a_half, b_half;
   logic [63:0]         pp;
   logic [2*WORD_W-1:0] pp_sh;
   logic [WORD_W:0]     rem_sh, rem_diff;
   logic                ge;

   // partial product for the current step
   always_comb begin
      a_half = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      case (step_ff[1:0])
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // one restoring divide step
   always_comb begin
      rem_sh   = {rem_ff, prod_ff[2*WORD_W-1]};
      rem_diff = rem_sh - {1'b0, d_ff};
      ge       = rem_sh >= {1'b0, d_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      mul_in   = mul_ff;
      done_in  = 1'b0;
      recip_in = recip_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         mul_in   = 1'b1;
         recip_in = recip;
         step_in  = 7'd0;
         a_in     = a;
         b_in     = b;
         d_in     = d;
         prod_in  = '0;
         rem_in   = '0;
         quot_in  = '0;
      end else if (busy_ff && mul_ff) begin
         prod_in = prod_ff + pp_sh;
         if (step_ff[1:0] == 2'd3) begin
            mul_in  = 1'b0;
            step_in = 7'd0;
            // reciprocal mode ends with the product
            if (recip_ff) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            step_in = step_ff + 7'd1;
         end
      end else if (busy_ff) begin
         prod_in = {prod_ff[2*WORD_W-2:0], 1'b0};
         rem_in  = ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
         quot_in = {quot_ff[WORD_W-2:0], ge};
         step_in = step_ff + 7'd1;
         if (step_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      recip_ff <= recip_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = recip_ff ? {{(SLACK_SHIFT-WORD_W){1'b0}}, prod_ff[2*WORD_W-1:SLACK_SHIFT]} :
                 (d_ff == '0) ? '0 : quot_ff;

endmodule

// ===== rtl/pae_datapath.sv =====
// ----------------------------------------------------------------------------
// pae_datapath
// Item and anchor registers, rate registers, shared mul-div unit, position
// settling and the result register.
// ----------------------------------------------------------------------------
module pae_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  pae_pkg::ctrl_cmd_type        ctrl,
   output pae_pkg::dp_status_type       status,
   input  logic                         cfg_we,
   input  logic                         cfg_idx,
   input  logic [pae_pkg::WORD_W-1:0]   cfg_wdata,
   output logic [pae_pkg::WORD_W-1:0]   stamp_rate,
   output logic [pae_pkg::WORD_W-1:0]   pos_rate,
   input  logic                         in_cmd,
   input  logic                         in_read_ok,
   input  logic [pae_pkg::WORD_W-1:0]   in_hw_pos,
   input  logic [pae_pkg::WORD_W-1:0]   in_hw_stamp,
   input  logic [pae_pkg::WORD_W-1:0]   in_now_stamp,
   input  logic signed [pae_pkg::WORD_W-1:0] in_song_ms,
   input  logic                         out_ready,
   output logic                         out_valid,
   output logic                         out_pos_valid,
   output logic [pae_pkg::WORD_W-1:0]   out_smooth_pos,
   output logic signed [pae_pkg::WORD_W-1:0] out_position_ms
);
   import pae_pkg::*;

   logic [WORD_W-1:0] stamp_rate_ff, pos_rate_ff;
   logic              cmd_ff, read_ok_ff;
   logic [WORD_W-1:0] hw_pos_ff, hw_stamp_ff, now_ff, song_ms_ff;
   logic              anchor_valid_ff, emitted_valid_ff, epoch_valid_ff;
   logic [WORD_W-1:0] anchor_pos_ff, anchor_stamp_ff, last_ff;
   logic [WORD_W-1:0] epoch_ms_ff, epoch_pos_ff;
   logic [WORD_W-1:0] from_hw_ff, pred_ff, slack_ff, pos_ff, dms_ff;
   logic [1:0]        sel_ff;
   logic              out_valid_ff, out_pos_valid_ff;
   logic [WORD_W-1:0] out_pos_ff, out_ms_ff;

   logic [WORD_W-1:0] div_a, div_b, div_d, quot, delta;
   logic              div_done, hw_gate, pred_gate;

   // settle signals
   logic              upd1, upd2;
   logic [WORD_W-1:0] a_pos1, pos1, pos2;

   // select divider operands
   always_comb begin
      delta = (pos_ff >= epoch_pos_ff) ? pos_ff - epoch_pos_ff : '0;
      case (ctrl.div_sel)
         DIV_HW: begin
            div_a = now_ff - hw_stamp_ff;
            div_b = pos_rate_ff;
            div_d = stamp_rate_ff;
         end
         DIV_PRED: begin
            div_a = now_ff - anchor_stamp_ff;
            div_b = pos_rate_ff;
            div_d = stamp_rate_ff;
         end
         DIV_SLACK: begin
            // divide by 1000 through a reciprocal multiply
            div_a = pos_rate_ff >> SLACK_PRESHIFT;
            div_b = SLACK_RECIP;
            div_d = SLACK_DIV;
         end
         default: begin
            div_a = delta;
            div_b = MS_PER_SEC;
            div_d = pos_rate_ff;
         end
      endcase
   end

   pae_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .recip (ctrl.div_sel == DIV_SLACK),
      .a     (div_a),
      .b     (div_b),
      .d     (div_d),
      .done  (div_done),
      .quot  (quot)
   );

   assign hw_gate   = (hw_stamp_ff != '0) && (now_ff > hw_stamp_ff);
   assign pred_gate = (anchor_stamp_ff != '0) && (now_ff > anchor_stamp_ff);

   // settle anchor and monotonic position
   always_comb begin
      upd1   = (hw_pos_ff != anchor_pos_ff) && ((from_hw_ff + slack_ff) >= pred_ff);
      a_pos1 = upd1 ? hw_pos_ff : anchor_pos_ff;
      pos1   = upd1 ? from_hw_ff : pred_ff;
      upd2   = (from_hw_ff > pos1) && (hw_pos_ff > a_pos1);
      pos2   = (from_hw_ff > pos1) ? from_hw_ff : pos1;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_rate_ff <= STAMP_RATE_RESET;
         pos_rate_ff   <= POS_RATE_RESET;
      end else if (cfg_we) begin
         if (cfg_idx == REG_STAMP_RATE) begin
            stamp_rate_ff <= cfg_wdata;
         end else begin
            pos_rate_ff <= cfg_wdata;
         end
      end
   end

   // capture item and divider results
   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         cmd_ff      <= in_cmd;
         read_ok_ff  <= in_read_ok;
         hw_pos_ff   <= in_hw_pos;
         hw_stamp_ff <= in_hw_stamp;
         now_ff      <= in_now_stamp;
         song_ms_ff  <= in_song_ms;
      end
      if (ctrl.div_start) begin
         sel_ff <= ctrl.div_sel;
      end
      if (ctrl.div_capture) begin
         case (sel_ff)
            DIV_HW:    from_hw_ff <= hw_pos_ff + (hw_gate ? quot : '0);
            DIV_PRED:  pred_ff <= anchor_pos_ff + (pred_gate ? quot : '0);
            DIV_SLACK: slack_ff <= (pos_rate_ff > SLACK_DIV) ? quot : 64'd1;
            default:   dms_ff <= quot;
         endcase
      end
   end

   // anchor, floor and epoch state
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_valid_ff  <= 1'b0;
         emitted_valid_ff <= 1'b0;
         epoch_valid_ff   <= 1'b0;
         anchor_pos_ff    <= '0;
         anchor_stamp_ff  <= '0;
         last_ff          <= '0;
         epoch_ms_ff      <= '0;
         epoch_pos_ff     <= '0;
      end else if (ctrl.out_load && cmd_ff == CMD_EPOCH) begin
         anchor_valid_ff  <= read_ok_ff;
         emitted_valid_ff <= read_ok_ff;
         epoch_valid_ff   <= read_ok_ff;
         epoch_ms_ff      <= song_ms_ff;
         if (read_ok_ff) begin
            anchor_pos_ff   <= hw_pos_ff;
            anchor_stamp_ff <= hw_stamp_ff;
            last_ff         <= from_hw_ff;
            epoch_pos_ff    <= from_hw_ff;
         end else begin
            last_ff      <= '0;
            epoch_pos_ff <= '0;
         end
      end else if (ctrl.settle) begin
         if (!anchor_valid_ff) begin
            anchor_valid_ff  <= 1'b1;
            anchor_pos_ff    <= hw_pos_ff;
            anchor_stamp_ff  <= hw_stamp_ff;
            last_ff          <= from_hw_ff;
            emitted_valid_ff <= 1'b1;
         end else begin
            if (upd1 || upd2) begin
               anchor_pos_ff   <= hw_pos_ff;
               anchor_stamp_ff <= hw_stamp_ff;
            end
            if (!(emitted_valid_ff && pos2 < last_ff)) begin
               last_ff          <= pos2;
               emitted_valid_ff <= 1'b1;
            end
         end
      end
   end

   // settled position
   always_ff @(posedge clock) begin
      if (ctrl.settle) begin
         if (!anchor_valid_ff) begin
            pos_ff <= from_hw_ff;
         end else if (emitted_valid_ff && pos2 < last_ff) begin
            pos_ff <= last_ff;
         end else begin
            pos_ff <= pos2;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (ctrl.out_load) begin
         if (cmd_ff == CMD_EPOCH) begin
            out_pos_valid_ff <= read_ok_ff;
            out_pos_ff       <= read_ok_ff ? from_hw_ff : '0;
            out_ms_ff        <= read_ok_ff ? song_ms_ff : '0;
         end else if (!epoch_valid_ff) begin
            out_pos_valid_ff <= 1'b0;
            out_pos_ff       <= '0;
            out_ms_ff        <= '0;
         end else if (!read_ok_ff) begin
            out_pos_valid_ff <= 1'b0;
            out_pos_ff       <= '0;
            out_ms_ff        <= epoch_ms_ff;
         end else begin
            out_pos_valid_ff <= 1'b1;
            out_pos_ff       <= pos_ff;
            out_ms_ff        <= epoch_ms_ff + dms_ff;
         end
      end
   end

   assign status.cmd         = cmd_ff;
   assign status.read_ok     = read_ok_ff;
   assign status.epoch_valid = epoch_valid_ff;
   assign status.div_done    = div_done;
   assign status.out_free    = !out_valid_ff || out_ready;

   assign stamp_rate      = stamp_rate_ff;
   assign pos_rate        = pos_rate_ff;
   assign out_valid       = out_valid_ff;
   assign out_pos_valid   = out_pos_valid_ff;
   assign out_smooth_pos  = out_pos_ff;
   assign out_position_ms = out_ms_ff;

endmodule

// ===== rtl/pae_ctrl.sv =====
// ----------------------------------------------------------------------------
// pae_ctrl
// Sequencer: takes an item, runs the divider passes it needs, settles the
// position and hands the result to the output register.
// ----------------------------------------------------------------------------
module pae_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pae_pkg::dp_status_type  status,
   output pae_pkg::ctrl_cmd_type   ctrl
);
   import pae_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_HW_WAIT    = 4'd2;
   localparam logic [3:0] S_PRED_WAIT  = 4'd3;
   localparam logic [3:0] S_SLACK_WAIT = 4'd4;
   localparam logic [3:0] S_SETTLE     = 4'd5;
   localparam logic [3:0] S_MS_START   = 4'd6;
   localparam logic [3:0] S_MS_WAIT    = 4'd7;
   localparam logic [3:0] S_FINISH     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in         = state_ff;
      ctrl             = '0;
      ctrl.div_sel     = DIV_HW;
      in_ready         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               ctrl.load_item = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // failed reads and queries before an epoch need no arithmetic
            if (!status.read_ok ||
                (status.cmd == CMD_QUERY && !status.epoch_valid)) begin
               state_in = S_FINISH;
            end else begin
               ctrl.div_start = 1'b1;
               ctrl.div_sel   = DIV_HW;
               state_in       = S_HW_WAIT;
            end
         end
         S_HW_WAIT: begin
            if (status.div_done) begin
               ctrl.div_capture = 1'b1;
               if (status.cmd == CMD_EPOCH) begin
                  state_in = S_FINISH;
               end else begin
                  ctrl.div_start = 1'b1;
                  ctrl.div_sel   = DIV_PRED;
                  state_in       = S_PRED_WAIT;
               end
            end
         end
         S_PRED_WAIT: begin
            if (status.div_done) begin
               ctrl.div_capture = 1'b1;
               ctrl.div_start   = 1'b1;
               ctrl.div_sel     = DIV_SLACK;
               state_in         = S_SLACK_WAIT;
            end
         end
         S_SLACK_WAIT: begin
            if (status.div_done) begin
               ctrl.div_capture = 1'b1;
               state_in         = S_SETTLE;
            end
         end
         S_SETTLE: begin
            ctrl.settle = 1'b1;
            state_in    = S_MS_START;
         end
         S_MS_START: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = DIV_MS;
            state_in       = S_MS_WAIT;
         end
         S_MS_WAIT: begin
            if (status.div_done) begin
               ctrl.div_capture = 1'b1;
               state_in         = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register is free
            if (status.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
